[design/hiaud_pkg.sv]
// ----------------------------------------------------------------------------
// hiaud_pkg
// Shared types, constants and helpers for the HEVC IRAP access-unit detector.
// ----------------------------------------------------------------------------
package hiaud_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HIST_W = 3 * BYTE_W;
  localparam int unsigned TYPE_W = 6;
  localparam int unsigned CNT_W  = 2;

  localparam logic [HIST_W-1:0] HIST_RESET = 24'hFF_FFFF;
  localparam logic [HIST_W-1:0] START_CODE = 24'h00_0001;

  localparam logic [BYTE_W-1:0] HDR0_RSVD_MASK = 8'h81;
  localparam logic [BYTE_W-1:0] HDR1_RSVD_MASK = 8'hF8;

  localparam logic [TYPE_W-1:0] IRAP_TYPE_MIN = 6'd16;
  localparam logic [TYPE_W-1:0] IRAP_TYPE_MAX = 6'd21;

  localparam logic [CNT_W-1:0] IRAP_CNT_ONE = 2'd1;
  localparam logic [CNT_W-1:0] IRAP_CNT_SAT = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    logic is_key_frame;
    logic header_violation;
  } result_t;

  // NAL unit type sits in bits 6:1 of the first header byte
  function automatic logic is_irap(input logic [BYTE_W-1:0] hdr0);
    logic [TYPE_W-1:0] nal_type;
    nal_type = hdr0[TYPE_W:1];
    return (nal_type >= IRAP_TYPE_MIN) && (nal_type <= IRAP_TYPE_MAX);
  endfunction

endpackage

[design/hiaud_if.sv]
// ----------------------------------------------------------------------------
// hiaud_if
// Valid/ready channels for bitstream bytes and detector results.
// ----------------------------------------------------------------------------
interface hiaud_in_if;
  logic                           valid;
  logic                           ready;
  logic [hiaud_pkg::BYTE_W-1:0]   data_byte;
  logic                           last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hiaud_out_if;
  logic valid;
  logic ready;
  logic is_key_frame;
  logic header_violation;

  modport source (output valid, output is_key_frame, output header_violation, input ready);
  modport sink   (input valid, input is_key_frame, input header_violation, output ready);
endinterface

[design/hevc_irap_access_unit_detector.sv]
// ----------------------------------------------------------------------------
// hevc_irap_access_unit_detector
// Scans an Annex-B byte stream and reports, per buffer, whether it carries
// exactly one IRAP NAL unit with clean header bits.
// ----------------------------------------------------------------------------
// Result path: a final-byte transaction lands in the input register; its result
//   is loaded into the result register once that register is free, raising out_valid.
// Throughput: one byte per cycle unless a final byte waits for a full result
//   register; the single scan stage between input and result registers updates buffer state.
// Reset: synchronous, active low; clears both stages and the scan state, no
//   clearing pass.
// ----------------------------------------------------------------------------
module hevc_irap_access_unit_detector (
  input  logic               clk,
  input  logic               rst_n,
  hiaud_in_if.sink           in_ch,
  hiaud_out_if.source        out_ch
);

  hiaud_pkg::item_t   in_item;
  hiaud_pkg::item_t   item;
  hiaud_pkg::result_t scan_res;
  hiaud_pkg::result_t out_res;
  logic               item_valid;
  logic               out_free;
  logic               take;

  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.last_byte = in_ch.last_byte;

  // advance unless a final byte waits for the result register
  assign take = item_valid && (!item.last_byte || out_free);

  hiaud_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  hiaud_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (item),
    .result (scan_res)
  );

  hiaud_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && item.last_byte),
    .load_res  (scan_res),
    .free      (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.is_key_frame     = out_res.is_key_frame;
  assign out_ch.header_violation = out_res.header_violation;

endmodule

[design/hiaud_in_stage.sv]
// ----------------------------------------------------------------------------
// hiaud_in_stage
// Input register: captures one byte transaction and holds it until consumed.
// ----------------------------------------------------------------------------
module hiaud_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hiaud_pkg::item_t  in_item,
  input  logic              take,
  output logic              item_valid,
  output hiaud_pkg::item_t  item
);

  logic             valid_r;
  logic             valid_nxt;
  hiaud_pkg::item_t item_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[design/hiaud_scan.sv]
// ----------------------------------------------------------------------------
// hiaud_scan
// Start-code search, NAL header checks and IRAP counting for one buffer.
// ----------------------------------------------------------------------------
module hiaud_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  hiaud_pkg::item_t   item,
  output hiaud_pkg::result_t result
);

  logic [hiaud_pkg::HIST_W-1:0] hist_r;
  logic [hiaud_pkg::HIST_W-1:0] hist_nxt;
  logic                         pend_r;
  logic                         pend_nxt;
  logic [hiaud_pkg::BYTE_W-1:0] hdr_r;
  logic [hiaud_pkg::BYTE_W-1:0] hdr_nxt;
  logic [hiaud_pkg::CNT_W-1:0]  cnt_r;
  logic [hiaud_pkg::CNT_W-1:0]  cnt_nxt;
  logic                         viol_r;
  logic                         viol_nxt;
  logic [hiaud_pkg::CNT_W-1:0]  cnt_upd;
  logic                         viol_upd;

  // Finish a pending header with this byte as the second header byte
  always_comb begin
    cnt_upd  = cnt_r;
    viol_upd = viol_r;
    if (pend_r) begin
      if (((hdr_r & hiaud_pkg::HDR0_RSVD_MASK) != '0) ||
          ((item.data_byte & hiaud_pkg::HDR1_RSVD_MASK) != '0)) begin
        viol_upd = 1'b1;
      end
      if (hiaud_pkg::is_irap(hdr_r) && (cnt_r != hiaud_pkg::IRAP_CNT_SAT)) begin
        cnt_upd = cnt_r + hiaud_pkg::IRAP_CNT_ONE;
      end
    end
  end

  assign result.is_key_frame     = (cnt_upd == hiaud_pkg::IRAP_CNT_ONE) && !viol_upd;
  assign result.header_violation = viol_upd;

  always_comb begin
    if (item.last_byte) begin
      // drop everything ready for the next buffer
      hist_nxt = hiaud_pkg::HIST_RESET;
      pend_nxt = 1'b0;
      hdr_nxt  = '0;
      cnt_nxt  = '0;
      viol_nxt = 1'b0;
    end else begin
      hist_nxt = {hist_r[hiaud_pkg::HIST_W-hiaud_pkg::BYTE_W-1:0], item.data_byte};
      pend_nxt = (hist_r == hiaud_pkg::START_CODE);
      hdr_nxt  = (hist_r == hiaud_pkg::START_CODE) ? item.data_byte : hdr_r;
      cnt_nxt  = cnt_upd;
      viol_nxt = viol_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= hiaud_pkg::HIST_RESET;
      pend_r <= 1'b0;
      hdr_r  <= '0;
      cnt_r  <= '0;
      viol_r <= 1'b0;
    end else if (take) begin
      hist_r <= hist_nxt;
      pend_r <= pend_nxt;
      hdr_r  <= hdr_nxt;
      cnt_r  <= cnt_nxt;
      viol_r <= viol_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.last_byte) |=> (hist_r == hiaud_pkg::HIST_RESET) && !pend_r &&
                                 (cnt_r == '0) && !viol_r)
    else $error("scan state not cleared after final byte");

  a_cnt_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == hiaud_pkg::IRAP_CNT_ONE) || (cnt_r == hiaud_pkg::IRAP_CNT_SAT) ||
    (cnt_r == '0))
    else $error("IRAP count beyond saturation");

  a_key_excl_viol: assert property (@(posedge clk) disable iff (!rst_n)
    result.is_key_frame |-> !result.header_violation)
    else $error("key frame flagged alongside header violation");
`endif

endmodule

[design/hiaud_out_stage.sv]
// ----------------------------------------------------------------------------
// hiaud_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module hiaud_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  hiaud_pkg::result_t load_res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output hiaud_pkg::result_t out_res
);

  logic               valid_r;
  logic               valid_nxt;
  hiaud_pkg::result_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
